>>> design/qrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_pkg
// Shared widths, the arctangent step table and the angle word type for the
// quaternion roll/pitch converter.
// ----------------------------------------------------------------------------
package qrp_pkg;

  // Vector component width: products scaled by 2^30 grow through CORDIC gain
  localparam int unsigned VecW   = 36;
  // Angle accumulator, 1/65536 centidegree units
  localparam int unsigned AngW   = 34;
  localparam int unsigned TabLen = 24;
  localparam logic signed [AngW-1:0] HalfTurn = AngW'(64'sd1179648000);

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AngW-1:0] ang_t;

  // atan(2^-i) in 1/65536 centidegree
  function automatic ang_t atan_step(input logic [4:0] idx);
    ang_t r;
    unique case (idx)
      5'd0:  r = AngW'(64'sd294912000);
      5'd1:  r = AngW'(64'sd174096719);
      5'd2:  r = AngW'(64'sd91987925);
      5'd3:  r = AngW'(64'sd46694507);
      5'd4:  r = AngW'(64'sd23437865);
      5'd5:  r = AngW'(64'sd11730358);
      5'd6:  r = AngW'(64'sd5866610);
      5'd7:  r = AngW'(64'sd2933484);
      5'd8:  r = AngW'(64'sd1466765);
      5'd9:  r = AngW'(64'sd733385);
      5'd10: r = AngW'(64'sd366693);
      5'd11: r = AngW'(64'sd183346);
      5'd12: r = AngW'(64'sd91673);
      5'd13: r = AngW'(64'sd45837);
      5'd14: r = AngW'(64'sd22918);
      5'd15: r = AngW'(64'sd11459);
      5'd16: r = AngW'(64'sd5730);
      5'd17: r = AngW'(64'sd2865);
      5'd18: r = AngW'(64'sd1432);
      5'd19: r = AngW'(64'sd716);
      5'd20: r = AngW'(64'sd358);
      5'd21: r = AngW'(64'sd179);
      5'd22: r = AngW'(64'sd90);
      5'd23: r = AngW'(64'sd45);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/qrp_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_cordic_cell
// One vectoring CORDIC iteration for two independent vectors (roll and
// pitch), registered, with a side-band word carried alongside.
// ----------------------------------------------------------------------------
module qrp_cordic_cell #(
  parameter int unsigned SHIFT  = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  qrp_pkg::vec_t         rx_in,
  input  qrp_pkg::vec_t         ry_in,
  input  qrp_pkg::ang_t         ra_in,
  input  qrp_pkg::vec_t         px_in,
  input  qrp_pkg::vec_t         py_in,
  input  qrp_pkg::ang_t         pa_in,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  vld_out,
  output qrp_pkg::vec_t         rx_out,
  output qrp_pkg::vec_t         ry_out,
  output qrp_pkg::ang_t         ra_out,
  output qrp_pkg::vec_t         px_out,
  output qrp_pkg::vec_t         py_out,
  output qrp_pkg::ang_t         pa_out,
  output logic [SIDE_W-1:0]     side_out
);

  localparam qrp_pkg::ang_t Step = qrp_pkg::atan_step(5'(SHIFT));

  logic          vld_r;
  qrp_pkg::vec_t rx_r, ry_r, px_r, py_r;
  qrp_pkg::ang_t ra_r, pa_r;
  logic [SIDE_W-1:0] side_r;

  // Rotate each vector towards the x axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      side_r <= side_in;
      if (!ry_in[qrp_pkg::VecW-1]) begin
        rx_r <= rx_in + (ry_in >>> SHIFT);
        ry_r <= ry_in - (rx_in >>> SHIFT);
        ra_r <= ra_in + Step;
      end else begin
        rx_r <= rx_in - (ry_in >>> SHIFT);
        ry_r <= ry_in + (rx_in >>> SHIFT);
        ra_r <= ra_in - Step;
      end
      if (!py_in[qrp_pkg::VecW-1]) begin
        px_r <= px_in + (py_in >>> SHIFT);
        py_r <= py_in - (px_in >>> SHIFT);
        pa_r <= pa_in + Step;
      end else begin
        px_r <= px_in - (py_in >>> SHIFT);
        py_r <= py_in + (px_in >>> SHIFT);
        pa_r <= pa_in - Step;
      end
    end
  end

  assign vld_out  = vld_r;
  assign rx_out   = rx_r;
  assign ry_out   = ry_r;
  assign ra_out   = ra_r;
  assign px_out   = px_r;
  assign py_out   = py_r;
  assign pa_out   = pa_r;
  assign side_out = side_r;

endmodule

>>> design/qrp_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrp_sqrt_cell
// One bit step of a restoring integer square root, registered, with a
// side-band word carried alongside.
// ----------------------------------------------------------------------------
module qrp_sqrt_cell #(
  parameter int unsigned BITPOS = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  logic [61:0]       rem_in,
  input  logic [30:0]       root_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_out,
  output logic [61:0]       rem_out,
  output logic [30:0]       root_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld_r;
  logic [61:0]       rem_r;
  logic [30:0]       root_r;
  logic [SIDE_W-1:0] side_r;
  logic [30:0]       trial;
  logic [62:0]       trial_sq;

  // Try setting this root bit; keep it when its square still fits
  assign trial    = root_in | (31'd1 << BITPOS);
  assign trial_sq = ({32'd0, root_in} << (BITPOS + 1))
                  + (63'd1 << (2 * BITPOS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      side_r <= side_in;
      if ({1'b0, rem_in} >= trial_sq) begin
        rem_r  <= 62'({1'b0, rem_in} - trial_sq);
        root_r <= trial;
      end else begin
        rem_r  <= rem_in;
        root_r <= root_in;
      end
    end
  end

  assign vld_out  = vld_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign side_out = side_r;

endmodule

>>> design/quaternion_to_roll_pitch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_roll_pitch_unit
// Roll and pitch in centidegrees from a Q1.15 unit quaternion, through a
// chain of square-root cells and a chain of CORDIC vectoring cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata: quat_w, quat_x, quat_y, quat_z
//  out_     master     tdata: roll_centideg, pitch_centideg, pad; tuser: flags
//
// One quaternion is taken every cycle unless the pipeline is halted. A result
// passes the products, the 31 square-root cells, the CORDIC cells and rounding.
// The whole pipeline advances together; it halts only when the output
// register holds a result that has not been taken. Reset clears valid flags.
// ----------------------------------------------------------------------------
module quaternion_to_roll_pitch_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // roll_centideg[15:0], pitch_centideg[30:16], 0
  output logic [2:0]  out_tuser   // pitch_clamped, roll_negative, pitch_negative
);

  localparam int unsigned NStg = (CORDIC_STAGES > qrp_pkg::TabLen) ?
                                 qrp_pkg::TabLen : CORDIC_STAGES;
  localparam int unsigned SqN  = 31;
  localparam int unsigned SideW = 2 * qrp_pkg::VecW + 2;
  localparam logic signed [qrp_pkg::VecW-1:0] OneQ30 = qrp_pkg::VecW'(64'sd1073741824);

  logic en;
  logic out_vld_r;

  // Advance everything unless the output register is stuck
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // ---- stage 1: products --------------------------------------------------
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = in_tdata[15:0];
  assign qx = in_tdata[31:16];
  assign qy = in_tdata[47:32];
  assign qz = in_tdata[63:48];

  logic s1_vld_r;
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
    if (en) begin
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      wy_r <= qw * qy;
      zx_r <= qz * qx;
    end
  end

  // ---- stage 2: roll vector and clamped pitch argument --------------------
  logic s2_vld_r, s2_clamp_r;
  qrp_pkg::vec_t s2_rc_r, s2_rs_r, s2_p_r;
  qrp_pkg::vec_t rs_w, rc_w, p_w;
  assign rs_w = (qrp_pkg::VecW'(wx_r) + qrp_pkg::VecW'(yz_r)) <<< 1;
  assign rc_w = OneQ30 - ((qrp_pkg::VecW'(xx_r) + qrp_pkg::VecW'(yy_r)) <<< 1);
  assign p_w  = (qrp_pkg::VecW'(wy_r) - qrp_pkg::VecW'(zx_r)) <<< 1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
    if (en) begin
      s2_rc_r <= rc_w;
      s2_rs_r <= rs_w;
      if (p_w > OneQ30) begin
        s2_p_r <= OneQ30;  s2_clamp_r <= 1'b1;
      end else if (p_w < -OneQ30) begin
        s2_p_r <= -OneQ30; s2_clamp_r <= 1'b1;
      end else begin
        s2_p_r <= p_w;     s2_clamp_r <= 1'b0;
      end
    end
  end

  // ---- stage 3: radicand 2^60 - P^2 (P^2 from a 31x16 and a 31x15 product) ---
  logic [30:0] pabs;
  assign pabs = s2_p_r[qrp_pkg::VecW-1] ? 31'(-s2_p_r) : 31'(s2_p_r);
  logic s3_vld_r;
  logic [46:0] plo_r, phi_r;
  logic [SideW-1:0] s3_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
    if (en) begin
      plo_r     <= 47'(pabs * pabs[15:0]);
      phi_r     <= 47'(pabs * pabs[30:16]);
      s3_side_r <= {s2_clamp_r, 1'b0, s2_rc_r, s2_rs_r};
    end
  end
  // Pitch argument travels through the roots chain too
  qrp_pkg::vec_t s3_p_r;
  always_ff @(posedge clk) if (en) s3_p_r <= s2_p_r;

  logic [61:0] rad;
  assign rad = 62'((63'd1 << 60) - ({16'd0, plo_r} + ({16'd0, phi_r} << 16)));

  // ---- square-root cell chain ----------------------------------------------
  localparam int unsigned SqSide = SideW + qrp_pkg::VecW;
  logic              sq_vld [SqN+1];
  logic [61:0]       sq_rem [SqN+1];
  logic [30:0]       sq_root[SqN+1];
  logic [SqSide-1:0] sq_side[SqN+1];
  assign sq_vld[0]  = s3_vld_r;
  assign sq_rem[0]  = rad;
  assign sq_root[0] = '0;
  assign sq_side[0] = {s3_p_r, s3_side_r};

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    qrp_sqrt_cell #(.BITPOS(SqN - 1 - g), .SIDE_W(SqSide)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(sq_vld[g]), .rem_in(sq_rem[g]), .root_in(sq_root[g]),
      .side_in(sq_side[g]),
      .vld_out(sq_vld[g+1]), .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1]),
      .side_out(sq_side[g+1])
    );
  end

  // ---- CORDIC pre-rotation: fold vectors with negative x ------------------
  qrp_pkg::vec_t e_rc, e_rs, e_p, e_pc;
  logic e_clamp;
  assign e_rs    = sq_side[SqN][qrp_pkg::VecW-1:0];
  assign e_rc    = sq_side[SqN][2*qrp_pkg::VecW-1:qrp_pkg::VecW];
  assign e_clamp = sq_side[SqN][SideW-1];
  assign e_p     = sq_side[SqN][SqSide-1:SideW];
  assign e_pc    = qrp_pkg::VecW'(sq_root[SqN]);

  qrp_pkg::vec_t c_rx0, c_ry0;
  qrp_pkg::ang_t c_ra0;
  always_comb begin
    if (e_rc[qrp_pkg::VecW-1]) begin
      c_rx0 = -e_rc;
      c_ry0 = -e_rs;
      c_ra0 = e_rs[qrp_pkg::VecW-1] ? -qrp_pkg::HalfTurn : qrp_pkg::HalfTurn;
    end else begin
      c_rx0 = e_rc;
      c_ry0 = e_rs;
      c_ra0 = '0;
    end
  end

  // side: clamp flag, roll-zero-y, roll-negative-x, pitch-zero-y
  logic [3:0] c_side0;
  assign c_side0 = {e_clamp, (e_rs == '0), e_rc[qrp_pkg::VecW-1], (e_p == '0)};

  // ---- CORDIC cell chain ---------------------------------------------------
  logic          cd_vld[NStg+1];
  qrp_pkg::vec_t cd_rx[NStg+1], cd_ry[NStg+1], cd_px[NStg+1], cd_py[NStg+1];
  qrp_pkg::ang_t cd_ra[NStg+1], cd_pa[NStg+1];
  logic [3:0]    cd_side[NStg+1];
  assign cd_vld[0]  = sq_vld[SqN];
  assign cd_rx[0]   = c_rx0;
  assign cd_ry[0]   = c_ry0;
  assign cd_ra[0]   = c_ra0;
  assign cd_px[0]   = e_pc;
  assign cd_py[0]   = e_p;
  assign cd_pa[0]   = '0;
  assign cd_side[0] = c_side0;

  for (genvar g = 0; g < NStg; g++) begin : g_cd
    qrp_cordic_cell #(.SHIFT(g), .SIDE_W(4)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(cd_vld[g]),
      .rx_in(cd_rx[g]), .ry_in(cd_ry[g]), .ra_in(cd_ra[g]),
      .px_in(cd_px[g]), .py_in(cd_py[g]), .pa_in(cd_pa[g]),
      .side_in(cd_side[g]),
      .vld_out(cd_vld[g+1]),
      .rx_out(cd_rx[g+1]), .ry_out(cd_ry[g+1]), .ra_out(cd_ra[g+1]),
      .px_out(cd_px[g+1]), .py_out(cd_py[g+1]), .pa_out(cd_pa[g+1]),
      .side_out(cd_side[g+1])
    );
  end

  // ---- round, clamp and hold result ---------------------------------------
  qrp_pkg::ang_t ra_rnd, pa_rnd;
  logic [3:0] fs;
  logic signed [17:0] roll_w, pitch_w;
  logic signed [15:0] roll_f;
  logic signed [14:0] pitch_f;
  assign fs     = cd_side[NStg];
  assign ra_rnd = (cd_ra[NStg] + qrp_pkg::AngW'(32768)) >>> 16;
  assign pa_rnd = (cd_pa[NStg] + qrp_pkg::AngW'(32768)) >>> 16;

  always_comb begin
    if (fs[2]) begin
      roll_w = fs[1] ? 18'sd18000 : 18'sd0;
    end else begin
      roll_w = 18'(ra_rnd);
    end
    pitch_w = fs[0] ? 18'sd0 : 18'(pa_rnd);
    if (roll_w > 18'sd18000)       roll_f = 16'sd18000;
    else if (roll_w < -18'sd18000) roll_f = -16'sd18000;
    else                           roll_f = 16'(roll_w);
    if (pitch_w > 18'sd9000)       pitch_f = 15'sd9000;
    else if (pitch_w < -18'sd9000) pitch_f = -15'sd9000;
    else                           pitch_f = 15'(pitch_w);
  end

  logic [31:0] out_data_r;
  logic [2:0]  out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cd_vld[NStg];
    end
    if (en) begin
      out_data_r <= {1'b0, pitch_f, roll_f};
      out_user_r <= {fs[3], roll_f[15], pitch_f[14]};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
